@@ design/vpdi_pkg.sv @@
`timescale 1ns / 1ps
package vpdi_pkg;

  typedef enum logic [2:0] {
    CMD_CTRL   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_READ   = 3'd2,
    CMD_STATUS = 3'd3,
    CMD_LINE   = 3'd4,
    CMD_ACK    = 3'd5,
    CMD_DMA    = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE     = 4'd0,
    OP_EXEC     = 4'd1,   // command work and stores, first VRAM byte
    OP_VWR2     = 4'd2,   // second VRAM byte of a word write
    OP_VRD1     = 4'd3,   // launch read of high VRAM byte
    OP_VRD2     = 4'd4,   // launch read of low VRAM byte
    OP_VRD3     = 4'd5,   // collect low byte
    OP_FILL     = 4'd6,   // one fill byte
    OP_CPRD     = 4'd7,   // copy: read source byte
    OP_CPWR     = 4'd8,   // copy: write destination byte
    OP_CLR      = 4'd9,   // clearing pass: one entry of every store
    OP_LOAD     = 4'd10   // latch input word
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       count_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       start_fill;
    logic       start_copy;
    logic       read_vram;
    logic       write_vram;
    logic       count_last;
    logic       clear_last;
  } dp_stat_t;

  localparam logic [4:0] REG_CTL0     = 5'd0;
  localparam logic [4:0] REG_CTL1     = 5'd1;
  localparam logic [4:0] REG_LINE_CNT = 5'd10;
  localparam logic [4:0] REG_INC      = 5'd15;
  localparam logic [4:0] REG_LEN_LO   = 5'd19;
  localparam logic [4:0] REG_LEN_HI   = 5'd20;
  localparam logic [4:0] REG_SRC_LO   = 5'd21;
  localparam logic [4:0] REG_SRC_MI   = 5'd22;
  localparam logic [4:0] REG_SRC_HI   = 5'd23;
  localparam int         NUM_REGS     = 24;

  localparam logic [3:0] SEL_VRAM_RD = 4'd0;
  localparam logic [3:0] SEL_VRAM_WR = 4'd1;
  localparam logic [3:0] SEL_CRAM_WR = 4'd3;
  localparam logic [3:0] SEL_VSRAM_RD = 4'd4;
  localparam logic [3:0] SEL_VSRAM_WR = 4'd5;
  localparam logic [3:0] SEL_CRAM_RD = 4'd8;

  localparam logic [15:0] STATUS_BASE   = 16'h3600;
  localparam logic [15:0] STATUS_VBLANK = 16'h0008;
  localparam logic [15:0] STATUS_VINT   = 16'h0080;
  localparam logic [15:0] STATUS_HBLANK = 16'h0004;

  localparam logic [2:0] IRQ_NONE = 3'd0;
  localparam logic [2:0] IRQ_H    = 3'd4;
  localparam logic [2:0] IRQ_V    = 3'd6;

endpackage

@@ design/vpdi_ctrl.sv @@
`timescale 1ns / 1ps
module vpdi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  vpdi_pkg::dp_stat_t  stat,
  output vpdi_pkg::dp_cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_EXEC  = 12'b000000000100,
    S_VWR2  = 12'b000000001000,
    S_VRD1  = 12'b000000010000,
    S_VRD2  = 12'b000000100000,
    S_VRD3  = 12'b000001000000,
    S_FILL  = 12'b000010000000,
    S_CPRD  = 12'b000100000000,
    S_CPWR  = 12'b001000000000,
    S_OUT   = 12'b010000000000,
    S_PRE   = 12'b100000000000
  } state_t;

  state_t state, state_next;

  // Result register is free once the previous word is taken.
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE) || !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd.op = vpdi_pkg::OP_IDLE;
    cmd.count_load = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.op = vpdi_pkg::OP_CLR;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && out_free) begin
          cmd.op = vpdi_pkg::OP_LOAD;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        cmd.count_load = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.op = vpdi_pkg::OP_EXEC;
        if (stat.start_fill) begin
          state_next = S_FILL;
        end else if (stat.start_copy) begin
          state_next = S_CPRD;
        end else if (stat.write_vram) begin
          state_next = S_VWR2;
        end else if (stat.read_vram) begin
          state_next = S_VRD1;
        end else begin
          state_next = S_OUT;
        end
      end
      S_VWR2: begin
        cmd.op = vpdi_pkg::OP_VWR2;
        state_next = S_OUT;
      end
      S_VRD1: begin
        cmd.op = vpdi_pkg::OP_VRD1;
        state_next = S_VRD2;
      end
      S_VRD2: begin
        cmd.op = vpdi_pkg::OP_VRD2;
        state_next = S_VRD3;
      end
      S_VRD3: begin
        cmd.op = vpdi_pkg::OP_VRD3;
        state_next = S_OUT;
      end
      S_FILL: begin
        cmd.op = vpdi_pkg::OP_FILL;
        if (stat.count_last) begin
          state_next = S_OUT;
        end
      end
      S_CPRD: begin
        cmd.op = vpdi_pkg::OP_CPRD;
        state_next = S_CPWR;
      end
      S_CPWR: begin
        cmd.op = vpdi_pkg::OP_CPWR;
        state_next = stat.count_last ? S_OUT : S_CPRD;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/vpdi_datapath.sv @@
`timescale 1ns / 1ps
module vpdi_datapath #(
  parameter int ACTIVE_LINES    = 224,
  parameter int CYCLES_PER_LINE = 488,
  parameter int SCROLL_WORDS    = 40
) (
  input  logic               clk,
  input  logic               rst,
  input  vpdi_pkg::dp_cmd_t  cmd,
  output vpdi_pkg::dp_stat_t stat,
  input  logic [2:0]         command,
  input  logic [15:0]        word,
  input  logic [8:0]         scanline,
  input  logic [2:0]         ack_level,
  input  logic [9:0]         cycles_into_line,
  output logic [15:0]        read_word,
  output logic [2:0]         irq_level,
  output logic               dma_request,
  output logic [23:0]        dma_source,
  output logic [16:0]        dma_length
);

  localparam int HBLANK_CYC = (CYCLES_PER_LINE * 3) / 4;

  logic [7:0]  vram [65536];
  logic [15:0] cram [64];
  logic [10:0] vsram [64];
  logic [7:0]  regs [vpdi_pkg::NUM_REGS];

  logic [2:0]  c_cmd;
  logic [15:0] c_word;
  logic [8:0]  c_line;
  logic [2:0]  c_lvl;
  logic [9:0]  c_cyc;

  logic        second_word;
  logic [5:0]  code;
  logic [16:0] addr;
  logic        fill_armed;
  logic        vpend, hpend, vflag;
  logic [7:0]  countdown;
  logic [2:0]  irq_held;

  logic [16:0] count;
  logic [15:0] copy_src;
  logic [7:0]  fill_byte;
  logic [7:0]  vram_q;
  logic [7:0]  hi_byte;
  logic [15:0] clr_idx;

  logic [15:0] rd;
  logic        req;
  logic [23:0] src_o;
  logic [16:0] len_o;

  // Combinational decode from latched item and state.
  logic [3:0]  sel;
  logic [15:0] ctrl_new_code_w;
  logic [5:0]  code2;
  logic [16:0] addr2;
  logic        dma_go;
  logic [1:0]  dma_mode;
  logic [16:0] dma_len;
  logic [16:0] addr_inc;
  logic [5:0]  word_idx;
  logic        idx_ok;
  logic [15:0] vaddr;
  logic [7:0]  cd_after;
  logic        h_after;

  assign sel = code[3:0];
  assign code2 = {c_word[7:4], code[1:0]};
  assign addr2 = {1'b0, c_word[1:0], addr[13:0]};
  assign dma_mode = regs[vpdi_pkg::REG_SRC_HI][7:6];
  assign dma_go = code2[5] && regs[vpdi_pkg::REG_CTL1][4];
  assign dma_len = ({regs[vpdi_pkg::REG_LEN_HI], regs[vpdi_pkg::REG_LEN_LO]} == 16'd0) ?
                   17'h10000 : {1'b0, regs[vpdi_pkg::REG_LEN_HI], regs[vpdi_pkg::REG_LEN_LO]};
  assign addr_inc = addr + {9'd0, regs[vpdi_pkg::REG_INC]};
  assign word_idx = addr[6:1];
  assign idx_ok = {26'd0, word_idx} < SCROLL_WORDS;
  assign vaddr = addr[15:0];
  assign ctrl_new_code_w = c_word;

  logic is_ctrl2, is_store, is_load;
  assign is_ctrl2 = (c_cmd == vpdi_pkg::CMD_CTRL) && second_word;
  assign is_store = (c_cmd == vpdi_pkg::CMD_DMA) ||
                    ((c_cmd == vpdi_pkg::CMD_WRITE) && !fill_armed);
  assign is_load = (c_cmd == vpdi_pkg::CMD_READ);

  always_comb begin
    stat.start_fill = (c_cmd == vpdi_pkg::CMD_WRITE) && fill_armed;
    stat.start_copy = is_ctrl2 && dma_go && (dma_mode == 2'd3);
    stat.write_vram = is_store && (sel == vpdi_pkg::SEL_VRAM_WR);
    stat.read_vram  = is_load && (sel == vpdi_pkg::SEL_VRAM_RD);
    stat.count_last = (count == 17'd1);
    stat.clear_last = (clr_idx == 16'hFFFF);
  end

  // Line counter results for the line start command.
  always_comb begin
    cd_after = countdown;
    h_after = hpend;
    if (c_line == 9'd0) begin
      cd_after = regs[vpdi_pkg::REG_LINE_CNT];
    end
    if ({23'd0, c_line} < ACTIVE_LINES) begin
      if (cd_after == 8'd0) begin
        cd_after = regs[vpdi_pkg::REG_LINE_CNT];
        h_after = 1'b1;
      end else begin
        cd_after = cd_after - 8'd1;
      end
    end else begin
      cd_after = regs[vpdi_pkg::REG_LINE_CNT];
    end
  end

  function automatic logic [2:0] irq_of(input logic v, input logic h,
                                        input logic [7:0] m1, input logic [7:0] m2);
    if (v && m2[5]) begin
      irq_of = vpdi_pkg::IRQ_V;
    end else if (h && m1[4]) begin
      irq_of = vpdi_pkg::IRQ_H;
    end else begin
      irq_of = vpdi_pkg::IRQ_NONE;
    end
  endfunction

  // Video RAM: byte wide, one write port and one registered read port.
  logic        vwe;
  logic [15:0] vwa;
  logic [7:0]  vwd;
  logic [15:0] vra;

  always_comb begin
    vwe = 1'b0;
    vwa = vaddr;
    vwd = 8'd0;
    vra = vaddr;
    unique case (cmd.op)
      vpdi_pkg::OP_CLR: begin
        vwe = 1'b1;
        vwa = clr_idx;
      end
      vpdi_pkg::OP_EXEC: begin
        vwe = stat.write_vram;
        vwa = vaddr & 16'hFFFE;
        vwd = vaddr[0] ? c_word[7:0] : c_word[15:8];
      end
      vpdi_pkg::OP_VWR2: begin
        vwe = 1'b1;
        vwa = vaddr | 16'h0001;
        vwd = vaddr[0] ? c_word[15:8] : c_word[7:0];
      end
      vpdi_pkg::OP_VRD1: vra = vaddr & 16'hFFFE;
      vpdi_pkg::OP_VRD2: vra = vaddr | 16'h0001;
      vpdi_pkg::OP_FILL: begin
        vwe = 1'b1;
        vwa = vaddr ^ 16'h0001;
        vwd = fill_byte;
      end
      vpdi_pkg::OP_CPRD: vra = copy_src;
      vpdi_pkg::OP_CPWR: begin
        vwe = 1'b1;
        vwd = vram_q;
      end
      default: begin
        vwe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vram[vwa] <= vwd;
    end
    vram_q <= vram[vra];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == vpdi_pkg::OP_CLR) begin
      cram[clr_idx[5:0]] <= 16'd0;
      vsram[clr_idx[5:0]] <= 11'd0;
    end else if (cmd.op == vpdi_pkg::OP_EXEC && is_store) begin
      if (sel == vpdi_pkg::SEL_CRAM_WR) begin
        cram[word_idx] <= c_word;
      end
      if (sel == vpdi_pkg::SEL_VSRAM_WR && idx_ok) begin
        vsram[word_idx] <= c_word[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == vpdi_pkg::OP_LOAD) begin
      c_cmd <= command;
      c_word <= word;
      c_line <= scanline;
      c_lvl <= ack_level;
      c_cyc <= cycles_into_line;
    end
    if (cmd.count_load) begin
      count <= dma_len;
      fill_byte <= c_word[15:8];
      copy_src <= {regs[vpdi_pkg::REG_SRC_MI], regs[vpdi_pkg::REG_SRC_LO]};
    end else if (cmd.op == vpdi_pkg::OP_FILL || cmd.op == vpdi_pkg::OP_CPWR) begin
      count <= count - 17'd1;
    end
    if (cmd.op == vpdi_pkg::OP_CPWR) begin
      copy_src <= copy_src + 16'd1;
    end
    if (cmd.op == vpdi_pkg::OP_VRD2) begin
      hi_byte <= vram_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= 16'd0;
      second_word <= 1'b0;
      code <= 6'd0;
      addr <= 17'd0;
      fill_armed <= 1'b0;
      vpend <= 1'b0;
      hpend <= 1'b0;
      vflag <= 1'b0;
      countdown <= 8'd0;
      irq_held <= vpdi_pkg::IRQ_NONE;
      for (int i = 0; i < vpdi_pkg::NUM_REGS; i++) begin
        regs[i] <= 8'd0;
      end
      rd <= 16'd0;
      req <= 1'b0;
      src_o <= 24'd0;
      len_o <= 17'd0;
    end else begin
      unique case (cmd.op)
        vpdi_pkg::OP_CLR: clr_idx <= clr_idx + 16'd1;
        vpdi_pkg::OP_LOAD: begin
          rd <= 16'd0;
          req <= 1'b0;
          src_o <= 24'd0;
          len_o <= 17'd0;
        end
        vpdi_pkg::OP_EXEC: begin
          unique case (c_cmd)
            vpdi_pkg::CMD_CTRL: begin
              if (!second_word) begin
                if ((c_word & 16'hE000) == 16'h8000) begin
                  if (c_word[12:8] < 5'd24) begin
                    regs[c_word[12:8]] <= c_word[7:0];
                  end
                  code <= 6'd0;
                end else begin
                  code <= {code[5:2], ctrl_new_code_w[15:14]};
                  addr <= {addr[16:14], c_word[13:0]};
                  second_word <= 1'b1;
                end
              end else begin
                second_word <= 1'b0;
                code <= code2;
                addr <= addr2;
                if (dma_go) begin
                  if (!dma_mode[1]) begin
                    req <= 1'b1;
                    src_o <= {regs[vpdi_pkg::REG_SRC_HI][6:0],
                              regs[vpdi_pkg::REG_SRC_MI], regs[vpdi_pkg::REG_SRC_LO], 1'b0};
                    len_o <= dma_len;
                  end else if (dma_mode == 2'd2) begin
                    fill_armed <= 1'b1;
                  end
                end
              end
            end
            vpdi_pkg::CMD_WRITE: begin
              second_word <= 1'b0;
              if (fill_armed) begin
                fill_armed <= 1'b0;
              end else if (sel != vpdi_pkg::SEL_VRAM_WR) begin
                addr <= addr_inc;
              end
            end
            // A video RAM store advances the address after its second byte.
            vpdi_pkg::CMD_DMA: begin
              if (sel != vpdi_pkg::SEL_VRAM_WR) begin
                addr <= addr_inc;
              end
            end
            vpdi_pkg::CMD_READ: begin
              second_word <= 1'b0;
              if (sel == vpdi_pkg::SEL_CRAM_RD) begin
                rd <= cram[word_idx];
              end else if (sel == vpdi_pkg::SEL_VSRAM_RD) begin
                rd <= {5'd0, vsram[idx_ok ? word_idx : 6'd0]};
              end
              if (sel != vpdi_pkg::SEL_VRAM_RD) begin
                addr <= addr_inc;
              end
            end
            vpdi_pkg::CMD_STATUS: begin
              second_word <= 1'b0;
              rd <= vpdi_pkg::STATUS_BASE
                  | ((({23'd0, c_line} >= ACTIVE_LINES) || !regs[vpdi_pkg::REG_CTL1][6]) ?
                     vpdi_pkg::STATUS_VBLANK : 16'd0)
                  | (vflag ? vpdi_pkg::STATUS_VINT : 16'd0)
                  | (({22'd0, c_cyc} > HBLANK_CYC) ? vpdi_pkg::STATUS_HBLANK : 16'd0);
            end
            vpdi_pkg::CMD_LINE: begin
              logic v_after;
              v_after = vpend;
              if ({23'd0, c_line} == ACTIVE_LINES) begin
                v_after = 1'b1;
                vflag <= 1'b1;
              end
              countdown <= cd_after;
              hpend <= h_after;
              vpend <= v_after;
              irq_held <= irq_of(v_after, h_after, regs[vpdi_pkg::REG_CTL0],
                                 regs[vpdi_pkg::REG_CTL1]);
            end
            vpdi_pkg::CMD_ACK: begin
              logic v_a, h_a;
              v_a = vpend;
              h_a = hpend;
              if (c_lvl == 3'd6) begin
                v_a = 1'b0;
                vflag <= 1'b0;
              end
              if (c_lvl == 3'd4) begin
                h_a = 1'b0;
              end
              vpend <= v_a;
              hpend <= h_a;
              irq_held <= irq_of(v_a, h_a, regs[vpdi_pkg::REG_CTL0],
                                 regs[vpdi_pkg::REG_CTL1]);
            end
            default: begin
              second_word <= second_word;
            end
          endcase
        end
        vpdi_pkg::OP_VWR2: addr <= addr_inc;
        vpdi_pkg::OP_VRD3: begin
          rd <= {hi_byte, vram_q};
          addr <= addr_inc;
        end
        vpdi_pkg::OP_FILL: addr <= addr_inc;
        vpdi_pkg::OP_CPWR: addr <= addr_inc;
        default: begin
          clr_idx <= clr_idx;
        end
      endcase
    end
  end

  assign read_word = rd;
  assign irq_level = irq_held;
  assign dma_request = req;
  assign dma_source = src_o;
  assign dma_length = len_o;

endmodule

@@ design/video_port_dma_interrupt_unit_top.sv @@
`timescale 1ns / 1ps
// Video port block: decodes two-word control writes and register writes, moves data words
// to and from video, color and scroll RAM with auto-increment, runs fill and copy DMA in
// video RAM, reports bus DMA as a request whose words return as dma word commands, answers
// status reads and raises line and frame interrupts. Every accepted word returns exactly
// one result word. After reset a clearing pass zeroes the memories, and no word is
// accepted until it ends. An ordinary command passes the load, prepare, execute and output
// states; a video RAM write adds a second byte-write state and a video RAM read adds the
// launch-high, launch-low and collect states, since video RAM is byte wide. A fill writes
// the DMA length in bytes, and a copy gives each byte one read and then one write.
module video_port_dma_interrupt_unit_top #(
  parameter int ACTIVE_LINES    = 224,
  parameter int CYCLES_PER_LINE = 488,
  parameter int SCROLL_WORDS    = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [15:0] word,
  input  logic [8:0]  scanline,
  input  logic [2:0]  ack_level,
  input  logic [9:0]  cycles_into_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] read_word,
  output logic [2:0]  irq_level,
  output logic        dma_request,
  output logic [23:0] dma_source,
  output logic [16:0] dma_length
);

  vpdi_pkg::dp_cmd_t  cmd;
  vpdi_pkg::dp_stat_t stat;

  vpdi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  vpdi_datapath #(
    .ACTIVE_LINES(ACTIVE_LINES), .CYCLES_PER_LINE(CYCLES_PER_LINE),
    .SCROLL_WORDS(SCROLL_WORDS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .command(command), .word(word), .scanline(scanline), .ack_level(ack_level),
    .cycles_into_line(cycles_into_line), .read_word(read_word), .irq_level(irq_level),
    .dma_request(dma_request), .dma_source(dma_source), .dma_length(dma_length)
  );

endmodule
